/* hdl/hfb_pkg.sv */
// ============================================================================
// hfb_pkg
// Shared types, character constants and conversion functions for the
// half-float base64 encoder.
// ============================================================================
package hfb_pkg;

    localparam int HFB_QUEUE_DEPTH = 4;

    localparam logic [6:0] HFB_CH_PAD = 7'h3D;
    localparam logic [6:0] HFB_CH_Q   = 7'h71;

    typedef enum logic [1:0] {
        PAD_NONE = 2'd0,
        PAD_ONE  = 2'd1,
        PAD_TWO  = 2'd2
    } t_pad;

    typedef struct packed {
        logic        pre;
        logic        grp;
        logic [23:0] grp_bits;
        t_pad        pad;
        logic [15:0] pad_bits;
        logic        last;
    } t_entry;

    function automatic logic [6:0] f_prefix(input logic [2:0] idx);
        logic [6:0] c;
        unique case (idx)
            3'd0:    c = 7'h71;
            3'd1:    c = 7'h2D;
            3'd2:    c = 7'h68;
            3'd3:    c = 7'h61;
            3'd4:    c = 7'h6E;
            3'd5:    c = 7'h64;
            3'd6:    c = 7'h3A;
            default: c = 7'h20;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] f_b64(input logic [5:0] v);
        logic [6:0] c;
        if (v < 6'd26) begin
            c = 7'h41 + {1'b0, v};
        end else if (v < 6'd52) begin
            c = 7'h47 + {1'b0, v};
        end else if (v < 6'd62) begin
            c = {1'b0, v} - 7'd4;
        end else if (v == 6'd62) begin
            c = 7'h2B;
        end else begin
            c = 7'h2F;
        end
        return c;
    endfunction

    function automatic logic [15:0] f_to_half(input logic [31:0] x);
        logic        s;
        logic [7:0]  ef;
        logic [22:0] fr;
        logic [4:0]  e5;
        logic [3:0]  sh;
        logic [23:0] m;
        logic [23:0] fa;
        logic [15:0] r;
        s  = x[31];
        ef = x[30:23];
        fr = x[22:0];
        e5 = 5'(ef - 8'd112);
        sh = 4'(8'd113 - ef);
        m  = {1'b1, fr} >> sh;
        fa = {1'b0, fr};
        if (ef == 8'hFF) begin
            r = {s, 5'h1F, (fr != 23'd0), 9'd0};
        end else if (ef >= 8'd143) begin
            r = {s, 5'h1F, 10'd0};
        end else if (ef <= 8'd112) begin
            if (ef < 8'd102) begin
                r = {s, 15'd0};
            end else begin
                if (m[12]) begin
                    m = m + 24'h2000;
                end
                r = {s, 4'd0, m[23:13]};
            end
        end else begin
            if (fr[12]) begin
                fa = fa + 24'h2000;
            end
            if (fa[23]) begin
                e5 = e5 + 5'd1;
            end
            if (e5 == 5'h1F) begin
                r = {s, 5'h1F, 10'd0};
            end else begin
                r = {s, e5, fa[22:13]};
            end
        end
        return r;
    endfunction

endpackage

/* hdl/hfb_if.sv */
// ============================================================================
// hfb_if
// Request channels: single-precision values in, characters out.
// ============================================================================
interface hfb_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_bits;
    logic        last_value;
    modport source(output valid, output value_bits, output last_value, input ready);
    modport sink(input valid, input value_bits, input last_value, output ready);
endinterface

interface hfb_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       message_end;
    logic       run_end;
    modport source(output valid, output char_code, output message_end, output run_end,
                   input ready);
    modport sink(input valid, input char_code, input message_end, input run_end,
                 output ready);
endinterface

/* hdl/half_float_base64_encoder_top.sv */
// An accepted value's character work is written into the queue, and the back
//   sequencer then reads it from there into the registered character output.
// The back sequencer sends one character per cycle while the output is ready;
//   a request yields 0, 4, 8 or 12 characters.
// Reset (synchronous, active low): empties the queue and output, drops held
//   bytes; the next value opens a new message with its prefix.
// ============================================================================
// half_float_base64_encoder_top
// Converts single-precision values to half precision and streams them as
// base64 text with a message prefix and padding.
// ============================================================================
module half_float_base64_encoder_top
    import hfb_pkg::*;
#(
    parameter int QUEUE_DEPTH = HFB_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hfb_in_if.sink      i_value,
    hfb_out_if.source   o_char
);

    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   q_valid;
    t_entry f_entry;
    t_entry q_entry;

    hfb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_value  (i_value),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_entry  (f_entry)
    );

    hfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (f_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    hfb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_entry   (q_entry),
        .o_pop     (q_pop),
        .o_char    (o_char)
    );

endmodule

/* hdl/hfb_front.sv */
// ============================================================================
// hfb_front
// Accepts values, converts to half precision, packs bytes into base64
// groups and queues the character work for each request.
// ============================================================================
module hfb_front
    import hfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    hfb_in_if.sink      i_value,
    input  logic        i_q_full,
    output logic        o_push,
    output t_entry      o_entry
);

    logic        r_at_start;
    logic [15:0] r_held;
    logic [1:0]  r_held_cnt;
    logic        n_at_start;
    logic [15:0] n_held;
    logic [1:0]  n_held_cnt;
    logic [15:0] half;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic        last;
    logic        accept;

    assign i_value.ready = !i_q_full;
    assign accept        = i_value.valid && !i_q_full;
    assign half          = f_to_half(i_value.value_bits);
    assign lo            = half[7:0];
    assign hi            = half[15:8];
    assign last          = i_value.last_value;

    always_comb begin
        o_entry.pre      = r_at_start;
        o_entry.grp      = 1'b0;
        o_entry.grp_bits = 24'd0;
        o_entry.pad      = PAD_NONE;
        o_entry.pad_bits = 16'd0;
        o_entry.last     = last;
        n_held           = 16'd0;
        n_held_cnt       = 2'd0;
        case (r_held_cnt)
            2'd0: begin
                if (last) begin
                    o_entry.pad      = PAD_TWO;
                    o_entry.pad_bits = {lo, hi};
                end
                n_held     = {lo, hi};
                n_held_cnt = 2'd2;
            end
            2'd1: begin
                o_entry.grp      = 1'b1;
                o_entry.grp_bits = {r_held[15:8], lo, hi};
            end
            2'd2: begin
                o_entry.grp      = 1'b1;
                o_entry.grp_bits = {r_held, lo};
                if (last) begin
                    o_entry.pad      = PAD_ONE;
                    o_entry.pad_bits = {hi, 8'd0};
                end
                n_held     = {hi, 8'd0};
                n_held_cnt = 2'd1;
            end
            default: begin
                o_entry.grp      = 1'b1;
                o_entry.grp_bits = {r_held, 8'd0};
                if (last) begin
                    o_entry.pad      = PAD_TWO;
                    o_entry.pad_bits = {lo, hi};
                end
                n_held     = {lo, hi};
                n_held_cnt = 2'd2;
            end
        endcase
        n_at_start = last;
        if (last) begin
            n_held     = 16'd0;
            n_held_cnt = 2'd0;
        end
    end

    assign o_push = accept && (o_entry.pre || o_entry.grp || (o_entry.pad != PAD_NONE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_held     <= 16'd0;
            r_held_cnt <= 2'd0;
        end else if (accept) begin
            r_at_start <= n_at_start;
            r_held     <= n_held;
            r_held_cnt <= n_held_cnt;
        end
    end

endmodule

/* hdl/hfb_queue.sv */
// ============================================================================
// hfb_queue
// Short queue of character work between the front and back parts.
// ============================================================================
module hfb_queue
    import hfb_pkg::*;
#(
    parameter int DEPTH = HFB_QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* hdl/hfb_back.sv */
// ============================================================================
// hfb_back
// Walks the queued work one character a cycle while the output accepts:
// prefix, full group, padded tail; drives the registered character output.
// ============================================================================
module hfb_back
    import hfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_entry      i_entry,
    output logic        o_pop,
    hfb_out_if.source   o_char
);

    logic [3:0] r_k;
    logic       r_valid;
    logic [6:0] r_code;
    logic       r_msg_end;
    logic       r_run_end;
    logic [3:0] j;
    logic [3:0] j2;
    logic [6:0] ch;
    logic       final_ch;
    logic       adv;
    logic [7:0] b0;
    logic [7:0] b1;

    assign b0 = i_entry.pad_bits[15:8];
    assign b1 = i_entry.pad_bits[7:0];
    assign j  = i_entry.pre ? (r_k - 4'd8) : r_k;
    assign j2 = i_entry.grp ? (j - 4'd4) : j;

    always_comb begin
        ch       = HFB_CH_PAD;
        final_ch = 1'b0;
        if (i_entry.pre && (r_k < 4'd8)) begin
            ch       = f_prefix(r_k[2:0]);
            final_ch = (r_k == 4'd7) && !i_entry.grp && (i_entry.pad == PAD_NONE);
        end else if (i_entry.grp && (j < 4'd4)) begin
            case (j[1:0])
                2'd0:    ch = f_b64(i_entry.grp_bits[23:18]);
                2'd1:    ch = f_b64(i_entry.grp_bits[17:12]);
                2'd2:    ch = f_b64(i_entry.grp_bits[11:6]);
                default: ch = f_b64(i_entry.grp_bits[5:0]);
            endcase
            final_ch = (j == 4'd3) && (i_entry.pad == PAD_NONE);
        end else begin
            case (j2[1:0])
                2'd0:    ch = f_b64(b0[7:2]);
                2'd1:    ch = f_b64({b0[1:0], b1[7:4]});
                2'd2:    ch = (i_entry.pad == PAD_TWO) ? f_b64({b1[3:0], 2'b00}) : HFB_CH_PAD;
                default: ch = HFB_CH_PAD;
            endcase
            final_ch = (j2 == 4'd3);
        end
    end

    assign adv   = i_q_valid && (!r_valid || o_char.ready);
    assign o_pop = adv && final_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= 4'd0;
            r_valid <= 1'b0;
        end else if (adv) begin
            r_k     <= final_ch ? 4'd0 : r_k + 4'd1;
            r_valid <= 1'b1;
        end else if (o_char.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_code    <= ch;
            r_run_end <= final_ch;
            r_msg_end <= final_ch && i_entry.last;
        end
    end

    assign o_char.valid       = r_valid;
    assign o_char.char_code   = r_code;
    assign o_char.message_end = r_msg_end;
    assign o_char.run_end     = r_run_end;

endmodule

/* hdl/hfb_checker.sv */
// ============================================================================
// hfb_checker
// Port-level checks on the character output of the encoder.
// ============================================================================
module hfb_checker
    import hfb_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [6:0] i_char_code,
    input logic       i_message_end,
    input logic       i_run_end
);

    logic r_after_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_end <= 1'b1;
        end else if (i_out_valid && i_out_ready) begin
            r_after_end <= i_message_end;
        end
    end

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output request dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_char_code) && $stable(i_message_end) && $stable(i_run_end))
        else $error("output payload changed while stalled");

    a_end_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_message_end |-> i_run_end)
        else $error("message end outside run end");

    a_prefix_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_after_end |-> i_char_code == HFB_CH_Q)
        else $error("message does not open with prefix");

endmodule

bind half_float_base64_encoder_top hfb_checker u_hfb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_char.valid),
    .i_out_ready   (o_char.ready),
    .i_char_code   (o_char.char_code),
    .i_message_end (o_char.message_end),
    .i_run_end     (o_char.run_end)
);

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Drives single-precision values into the half-float base64 encoder and
// checks every output character against typed text for some directed rows,
// else against a predictor of the half conversion, byte grouping, padding
// and message prefix, under random stalls on both channels and a hold-off.
// ============================================================================
module testbench;
    import hfb_pkg::*;

    localparam int          RESET_CYCLES     = 10;
    localparam int          DIRECTED_COUNT   = 26;
    localparam int          RANDOM_PER_PHASE = 65;
    localparam int          HOLD_OFF_CYCLES  = 300;
    localparam int          DRAIN_CYCLES     = 40;
    localparam int unsigned CYCLE_LIMIT      = 200000;
    localparam string       PREFIX_TEXT      = "q-hand: ";
    localparam string       B64_ALPHABET     =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [6:0] code;
        logic       msg_end;
        logic       run_end;
    } t_char;

    typedef struct {
        logic [31:0] bits;
        logic        last;
        string       typed;
    } t_value_row;

    logic i_clk;
    logic i_rst_n;

    hfb_in_if  value_if ();
    hfb_out_if char_if ();

    half_float_base64_encoder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_value (value_if),
        .o_char  (char_if)
    );

    t_char pending_chars[$];
    t_char item_chars[$];
    int    mismatch_count = 0;
    int    tx_idle_pct    = 0;
    int    rx_idle_pct    = 0;
    bit    hold_off_req   = 1'b0;

    logic        at_msg_start = 1'b1;
    logic [15:0] held_bytes   = '0;
    logic [1:0]  held_count   = '0;

    t_value_row directed_rows [DIRECTED_COUNT] = '{
        '{32'h0000_0000, 1'b1, "q-hand: AAA="},
        '{32'h7F80_0000, 1'b1, "q-hand: AHw="},
        '{32'hFF80_0000, 1'b1, "q-hand: APw="},
        '{32'h7FC0_0000, 1'b1, "q-hand: AH4="},
        '{32'hFFFF_FFFF, 1'b1, "q-hand: AP4="},
        '{32'h7F80_0001, 1'b1, "q-hand: AH4="},
        '{32'h4780_0000, 1'b1, "q-hand: AHw="},
        '{32'h477F_F000, 1'b1, ""},
        '{32'h477F_E000, 1'b1, ""},
        '{32'h0000_0001, 1'b1, "q-hand: AAA="},
        '{32'h8000_0001, 1'b1, ""},
        '{32'h3380_0000, 1'b1, ""},
        '{32'h3300_0000, 1'b1, ""},
        '{32'h32FF_FFFF, 1'b1, ""},
        '{32'h387F_F000, 1'b1, ""},
        '{32'h3880_0000, 1'b1, ""},
        '{32'h3F80_1000, 1'b1, ""},
        '{32'h3F80_0FFF, 1'b1, ""},
        '{32'hC2F6_E979, 1'b0, ""},
        '{32'h4049_0FDB, 1'b0, ""},
        '{32'h3DCC_CCCD, 1'b0, ""},
        '{32'hBF80_0000, 1'b0, ""},
        '{32'h4120_0000, 1'b1, ""},
        '{32'h4000_0000, 1'b0, ""},
        '{32'h4040_0000, 1'b0, ""},
        '{32'h4080_0000, 1'b1, ""}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] half_of(input logic [31:0] x);
        logic [15:0] sgn;
        int          exp8;
        int          biased;
        logic [23:0] sig;
        sgn    = {x[31], 15'd0};
        exp8   = int'(x[30:23]);
        biased = exp8 - 112;
        if (exp8 == 255) begin
            return sgn | 16'h7C00 | ((x[22:0] != 23'd0) ? 16'h0200 : 16'h0000);
        end
        if (biased >= 31) begin
            return sgn | 16'h7C00;
        end
        if (biased <= 0) begin
            if (biased < -10) begin
                return sgn;
            end
            sig = {1'b1, x[22:0]} >> (1 - biased);
            if (sig[12]) begin
                sig = sig + 24'h2000;
            end
            return sgn | 16'(sig >> 13);
        end
        sig = {1'b0, x[22:0]};
        if (sig[12]) begin
            sig = sig + 24'h2000;
            if (sig[23]) begin
                sig    = '0;
                biased = biased + 1;
            end
            if (biased >= 31) begin
                return sgn | 16'h7C00;
            end
        end
        return sgn | 16'(biased << 10) | 16'(sig >> 13);
    endfunction

    function automatic void push_code(input logic [6:0] code);
        t_char c;
        c.code    = code;
        c.msg_end = 1'b0;
        c.run_end = 1'b0;
        item_chars.insert(item_chars.size(), c);
    endfunction

    function automatic logic [6:0] b64_code(input logic [5:0] v);
        return 7'(B64_ALPHABET[v]);
    endfunction

    function automatic void encode_value(input logic [31:0] bits, input logic last);
        logic [15:0] hw;
        logic [7:0]  byte_q[$];
        logic [23:0] grp;
        int          rem;
        item_chars.delete();
        hw = half_of(bits);
        if (at_msg_start) begin
            for (int i = 0; i < 8; i++) begin
                push_code(7'(PREFIX_TEXT[i]));
            end
            at_msg_start = 1'b0;
        end
        if (held_count >= 2'd1) byte_q.insert(byte_q.size(), held_bytes[15:8]);
        if (held_count >= 2'd2) byte_q.insert(byte_q.size(), held_bytes[7:0]);
        byte_q.insert(byte_q.size(), hw[7:0]);
        byte_q.insert(byte_q.size(), hw[15:8]);
        while (byte_q.size() >= 3) begin
            grp = {byte_q[0], byte_q[1], byte_q[2]};
            void'(byte_q.pop_front());
            void'(byte_q.pop_front());
            void'(byte_q.pop_front());
            push_code(b64_code(grp[23:18]));
            push_code(b64_code(grp[17:12]));
            push_code(b64_code(grp[11:6]));
            push_code(b64_code(grp[5:0]));
        end
        rem = byte_q.size();
        if (last) begin
            if (rem > 0) begin
                grp = {byte_q[0], (rem > 1) ? byte_q[1] : 8'h00, 8'h00};
                push_code(b64_code(grp[23:18]));
                push_code(b64_code(grp[17:12]));
                push_code((rem > 1) ? b64_code(grp[11:6]) : HFB_CH_PAD);
                push_code(HFB_CH_PAD);
            end
            held_bytes   = '0;
            held_count   = '0;
            at_msg_start = 1'b1;
        end else begin
            held_count = 2'(rem);
            held_bytes = {(rem >= 1) ? byte_q[0] : 8'h00, (rem >= 2) ? byte_q[1] : 8'h00};
        end
        if (item_chars.size() > 0) begin
            item_chars[item_chars.size() - 1].run_end = 1'b1;
            item_chars[item_chars.size() - 1].msg_end = last;
        end
    endfunction

    function automatic logic [31:0] pick_value();
        int          kind;
        logic [31:0] v;
        kind = $urandom_range(9);
        v    = $urandom();
        case (kind)
            3: v[30:23] = 8'hFF;
            4: v[30:23] = 8'(141 + $urandom_range(2));
            5: v[30:23] = 8'(100 + $urandom_range(14));
            6: begin
                v[30:23] = 8'(113 + $urandom_range(29));
                v[12:0]  = {1'b1, 12'($urandom_range(3))};
            end
            7: v[30:0] = 31'($urandom_range(3));
            8: v[30:23] = 8'(113 + $urandom_range(29));
            9: begin
                v[30:23] = 8'(112 + $urandom_range(31));
                v[22:12] = '1;
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic offer_value(input logic [31:0] bits, input logic last, input string typed);
        int    n;
        t_char c;
        while ($urandom_range(99) < tx_idle_pct) begin
            value_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        value_if.valid      <= 1'b1;
        value_if.value_bits <= bits;
        value_if.last_value <= last;
        @(posedge i_clk);
        while (!value_if.ready) @(posedge i_clk);
        encode_value(bits, last);
        if (typed.len() == 0) begin
            foreach (item_chars[i]) pending_chars.insert(pending_chars.size(), item_chars[i]);
        end else begin
            n = typed.len();
            for (int i = 0; i < n; i++) begin
                c.code    = 7'(typed[i]);
                c.msg_end = last && (i == n - 1);
                c.run_end = (i == n - 1);
                pending_chars.insert(pending_chars.size(), c);
            end
        end
    endtask

    task automatic check_char();
        t_char want;
        if (pending_chars.size() == 0) begin
            $error("char_code: expected none, actual 0x%02h", char_if.char_code);
            mismatch_count++;
            return;
        end
        want = pending_chars.pop_front();
        if (char_if.char_code !== want.code) begin
            $error("char_code: expected 0x%02h, actual 0x%02h", want.code, char_if.char_code);
            mismatch_count++;
        end
        if (char_if.message_end !== want.msg_end) begin
            $error("message_end: expected %0b, actual %0b", want.msg_end, char_if.message_end);
            mismatch_count++;
        end
        if (char_if.run_end !== want.run_end) begin
            $error("run_end: expected %0b, actual %0b", want.run_end, char_if.run_end);
            mismatch_count++;
        end
    endtask

    initial begin : char_sink
        int hold_left;
        hold_left = 0;
        char_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && char_if.valid && char_if.ready) check_char();
            if (hold_off_req) begin
                hold_left    = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                char_if.ready <= 1'b0;
            end else begin
                char_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    initial begin : value_source
        int items_left;
        int msg_len;
        value_if.valid      <= 1'b0;
        value_if.value_bits <= '0;
        value_if.last_value <= 1'b0;
        i_rst_n             <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_COUNT; r++) begin
            offer_value(directed_rows[r].bits, directed_rows[r].last, directed_rows[r].typed);
        end

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 87 : 0;
            rx_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 30 : 0;
            if (phase == 2) hold_off_req = 1'b1;
            items_left = RANDOM_PER_PHASE;
            while (items_left > 0) begin
                msg_len = ($urandom_range(3) == 0) ? $urandom_range(20, 7) : $urandom_range(1, 6);
                if (msg_len > items_left) msg_len = items_left;
                for (int i = 0; i < msg_len; i++) begin
                    offer_value(pick_value(), (i == msg_len - 1), "");
                    items_left--;
                end
            end
        end
        value_if.valid <= 1'b0;

        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_chars.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
